/* hw/rtl/skc_pkg.sv */
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types and constants for the solitaire keystream generator core.
// ----------------------------------------------------------------------------
package skc_pkg;

   // Width of one card code and of lengths and counts over the deck
   localparam int CARD_W = 6;
   localparam int LEN_W  = 7;

   // Per-cycle command broadcast to every cell of the deck
   typedef struct packed {
      logic              rotate;   // rotate the prefix of length len left by one
      logic [LEN_W-1:0]  len;      // prefix length taking part in the rotation
      logic              load;     // write load_card into the cell at pos
      logic [CARD_W-1:0] pos;      // position addressed by a load
   } cell_ctrl_type;

endpackage

/* hw/rtl/skc_cell.sv */
// ----------------------------------------------------------------------------
// skc_cell
// One deck position. Holds a card, takes its right neighbour's card or the
// head card during a prefix rotation, or takes a loaded card.
// ----------------------------------------------------------------------------
module skc_cell #(
   parameter int INDEX = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  skc_pkg::cell_ctrl_type      ctrl,
   input  logic [skc_pkg::CARD_W-1:0]  load_card,
   input  logic [skc_pkg::CARD_W-1:0]  right_card,
   input  logic [skc_pkg::CARD_W-1:0]  head_card,
   output logic [skc_pkg::CARD_W-1:0]  card
);
   import skc_pkg::*;

   localparam logic [LEN_W-1:0]  NEXT_IDX = LEN_W'(INDEX + 1);
   localparam logic [CARD_W-1:0] OWN_POS  = CARD_W'(INDEX);

   logic [CARD_W-1:0] card_ff;
   logic [CARD_W-1:0] card_in;

   // Select the next card: load wins, then rotation, else hold
   always_comb begin
      card_in = card_ff;
      if (ctrl.load && ctrl.pos == OWN_POS) begin
         card_in = load_card;
      end else if (ctrl.rotate && NEXT_IDX < ctrl.len) begin
         card_in = right_card;
      end else if (ctrl.rotate && NEXT_IDX == ctrl.len) begin
         card_in = head_card;
      end
   end

   // Hold the card; reset gives the identity order
   always_ff @(posedge clock) begin
      if (reset) begin
         card_ff <= OWN_POS;
      end else begin
         card_ff <= card_in;
      end
   end

   assign card = card_ff;

endmodule

/* hw/rtl/solitaire_keystream_generator_core.sv */
// ----------------------------------------------------------------------------
// solitaire_keystream_generator_core
// Solitaire keystream deck held in a row of cells that rotate by prefix.
// ----------------------------------------------------------------------------
// Timing: each scan or cut rotates the cell row one place a cycle, and a
// result is registered in S_RESULT after its last pass, once the previous
// response has been taken.
// Throughput: one transfer at a time; the next is taken once the deck is idle.
// Reset: synchronous; the deck returns to the identity order.
module solitaire_keystream_generator_core #(
   parameter int DECK_SIZE = 54
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [5:0]                  req_position,
   input  logic [5:0]                  req_card_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [5:0]                  rsp_pad_value,
   output logic                        rsp_pad_valid
);
   import skc_pkg::*;

   localparam logic [LEN_W-1:0]  NL      = LEN_W'(DECK_SIZE);
   localparam logic [LEN_W-1:0]  NL_M1   = LEN_W'(DECK_SIZE - 1);
   localparam logic [LEN_W-1:0]  LEN_TWO = LEN_W'(2);
   localparam logic [CARD_W-1:0] JOKER_A = CARD_W'(DECK_SIZE - 2);
   localparam logic [CARD_W-1:0] JOKER_B = CARD_W'(DECK_SIZE - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_MOVE_A, S_MOVE_B1, S_MOVE_B2, S_FIND, S_CUT_LO, S_CUT_HI,
      S_COUNT_SET, S_COUNT, S_PAD_SET, S_PAD, S_RESULT
   } state_type;

   state_type         state_ff;
   logic [LEN_W-1:0]  cnt_ff;
   logic [LEN_W-1:0]  lim_ff;
   logic [LEN_W-1:0]  hi_ff;
   logic [LEN_W-1:0]  pa_ff;
   logic [LEN_W-1:0]  pb_ff;
   logic              fa_ff;
   logic              fb_ff;
   logic              swapped_ff;
   logic [CARD_W-1:0] pad_card_ff;
   logic              rsp_valid_ff;
   logic [CARD_W-1:0] pad_value_ff;
   logic              pad_valid_ff;

   logic [CARD_W-1:0] deck [DECK_SIZE];
   logic [CARD_W-1:0] head;
   logic [CARD_W-1:0] tail;
   logic [CARD_W-1:0] target;
   logic              hit;
   logic              req_accept;
   state_type         move_next;
   cell_ctrl_type     ctrl;
   logic [LEN_W-1:0]  tail_sum;
   logic [LEN_W-1:0]  head_sum;

   assign head       = deck[0];
   assign tail       = deck[DECK_SIZE-1];
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign tail_sum   = {1'b0, tail} + LEN_W'(1);
   assign head_sum   = {1'b0, head} + LEN_W'(1);

   // Row of deck cells; the last cell has no right neighbour
   for (genvar i = 0; i < DECK_SIZE; i++) begin : g_cell
      logic [CARD_W-1:0] right_w;
      if (i == DECK_SIZE - 1) begin : g_last
         assign right_w = deck[i];
      end else begin : g_mid
         assign right_w = deck[i+1];
      end
      skc_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .load_card  (req_card_value),
         .right_card (right_w),
         .head_card  (head),
         .card       (deck[i])
      );
   end

   // Pick the joker moved down in this pass and the pass that follows
   always_comb begin
      target    = JOKER_B;
      move_next = S_FIND;
      unique case (state_ff)
         S_MOVE_A: begin
            target    = JOKER_A;
            move_next = S_MOVE_B1;
         end
         S_MOVE_B1: move_next = S_MOVE_B2;
         default: ;
      endcase
   end

   assign hit = !swapped_ff && head == target;

   // Drive the cell command for the current pass
   always_comb begin
      ctrl        = '0;
      ctrl.len    = NL;
      unique case (state_ff)
         S_IDLE: begin
            ctrl.load = req_accept && req_func;
            ctrl.pos  = req_position;
         end
         S_MOVE_A, S_MOVE_B1, S_MOVE_B2: begin
            ctrl.rotate = (cnt_ff != NL);
            ctrl.len    = hit ? LEN_TWO : NL;
         end
         S_FIND, S_PAD: ctrl.rotate = (cnt_ff != NL);
         S_CUT_LO: begin
            ctrl.rotate = (cnt_ff != lim_ff);
            ctrl.len    = hi_ff + LEN_W'(1);
         end
         S_CUT_HI: ctrl.rotate = (cnt_ff != lim_ff);
         S_COUNT: begin
            ctrl.rotate = (cnt_ff != lim_ff);
            ctrl.len    = NL_M1;
         end
         default: ;
      endcase
   end

   // Sequence the passes and hold the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fa_ff        <= 1'b0;
         fb_ff        <= 1'b0;
         swapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_RESULT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= req_func ? S_PAD_SET : S_MOVE_A;
                  cnt_ff   <= '0;
               end
            end
            S_MOVE_A, S_MOVE_B1, S_MOVE_B2: begin
               // swap at the first hit, then finish the full turn
               if (cnt_ff == NL) begin
                  state_ff   <= move_next;
                  cnt_ff     <= '0;
                  swapped_ff <= 1'b0;
               end else if (hit) begin
                  if (cnt_ff == NL_M1) begin
                     state_ff   <= move_next;
                     cnt_ff     <= '0;
                     swapped_ff <= 1'b0;
                  end else begin
                     swapped_ff <= 1'b1;
                  end
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            S_FIND: begin
               if (cnt_ff == NL) begin
                  cnt_ff <= '0;
                  fa_ff  <= 1'b0;
                  fb_ff  <= 1'b0;
                  lim_ff <= (pa_ff < pb_ff) ? pa_ff : pb_ff;
                  hi_ff  <= (pa_ff < pb_ff) ? pb_ff : pa_ff;
                  state_ff <= (fa_ff && fb_ff) ? S_CUT_LO : S_COUNT_SET;
               end else begin
                  if (!fa_ff && head == JOKER_A) begin
                     fa_ff <= 1'b1;
                     pa_ff <= cnt_ff;
                  end
                  if (!fb_ff && head == JOKER_B) begin
                     fb_ff <= 1'b1;
                     pb_ff <= cnt_ff;
                  end
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            S_CUT_LO: begin
               if (cnt_ff == lim_ff) begin
                  lim_ff   <= hi_ff + LEN_W'(1);
                  cnt_ff   <= '0;
                  state_ff <= S_CUT_HI;
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            S_CUT_HI: begin
               if (cnt_ff == lim_ff) begin
                  cnt_ff   <= '0;
                  state_ff <= S_COUNT_SET;
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            S_COUNT_SET: begin
               lim_ff   <= (tail_sum > NL_M1) ? NL_M1 : tail_sum;
               state_ff <= S_COUNT;
            end
            S_COUNT: begin
               if (cnt_ff == lim_ff) begin
                  cnt_ff   <= '0;
                  state_ff <= S_PAD_SET;
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            S_PAD_SET: begin
               lim_ff   <= (head_sum > NL_M1) ? NL_M1 : head_sum;
               state_ff <= S_PAD;
            end
            S_PAD: begin
               // read the indexed card on the way round
               if (cnt_ff == lim_ff) begin
                  pad_card_ff <= head;
               end
               if (cnt_ff == NL) begin
                  cnt_ff   <= '0;
                  state_ff <= S_RESULT;
               end else begin
                  cnt_ff <= cnt_ff + LEN_W'(1);
               end
            end
            S_RESULT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  pad_value_ff <= (pad_card_ff > JOKER_A) ? JOKER_A : pad_card_ff;
                  pad_valid_ff <= (pad_card_ff < JOKER_A);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pad_value = pad_value_ff;
   assign rsp_pad_valid = pad_valid_ff;

endmodule
